>>> design/lru_page_replacement_macros.svh
// ----------------------------------------------------------------------------
// LRU page replacement - assertion macros
// Shared forms for the concurrent checks of the block, clocked on i_clk and
// held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRUPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Constants, state encoding and interface structs for the LRU page
// replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int CFG_W          = 4;
    localparam int FRAME_IDX_W    = 3;
    localparam int FAULT_W        = 16;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } t_eng_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [FAULT_W-1:0]     fault_count;
    } t_res_ctl;

endpackage

>>> design/lrupr_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_frame_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrupr_frame_mem import lrupr_pkg::*; #(
    parameter int DEPTH = MAX_FRAMES_DEF,
    parameter int WIDTH = PAGE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/lrupr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_engine
// Lookup pass over the active frames (hit, first empty, oldest), then an
// ageing pass that rewrites each valid frame's rank and installs the new page.
// ----------------------------------------------------------------------------
module lrupr_engine import lrupr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_last,
    input  logic [CFG_W-1:0]     i_frames_in_use,
    input  logic                 i_res_take,
    output t_eng_status          o_status,
    output t_res_ctl             o_res,
    output logic [PAGE_BITS-1:0] o_res_page
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RW = AW;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int WW = PAGE_BITS + RW;

    localparam logic [CW-1:0] MAX_N    = CW'(MAX_FRAMES);
    localparam logic [RW-1:0] RANK_TOP = RW'(MAX_FRAMES - 1);

    t_eng_state r_state, n_state;

    logic [CW-1:0]         n_act;
    logic [CW-1:0]         act_m1;
    logic [CW-1:0]         r_rd_cnt;
    logic                  r_dv;
    logic [AW-1:0]         r_di;
    logic [MAX_FRAMES-1:0] r_fvalid;
    logic [FAULT_W-1:0]    r_faults;

    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_last;
    logic                  r_found;
    logic [AW-1:0]         r_hit_idx;
    logic [RW-1:0]         r_hit_rank;
    logic                  r_empty;
    logic [AW-1:0]         r_empty_idx;
    logic [AW-1:0]         r_old_idx;
    logic [RW-1:0]         r_old_rank;
    logic [PAGE_BITS-1:0]  r_old_page;
    logic [AW-1:0]         r_sel;
    logic [CW-1:0]         r_old_age;
    logic                  r_ev;

    logic                  rd_en;
    logic [WW-1:0]         rd_data;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [RW-1:0]         rd_rank;
    logic                  ent_v;
    logic                  pass_last;
    logic                  wr_en;
    logic [WW-1:0]         wr_data;
    logic [RW-1:0]         aged;

    // active frame count: zero acts as one, oversize clamps
    always_comb begin
        if (i_frames_in_use == '0) begin
            n_act = CW'(1);
        end else if (int'(i_frames_in_use) > MAX_FRAMES) begin
            n_act = MAX_N;
        end else begin
            n_act = CW'(i_frames_in_use);
        end
    end

    assign act_m1    = n_act - CW'(1);
    assign rd_en     = ((r_state == ST_SCAN) || (r_state == ST_UPDATE)) && (r_rd_cnt < n_act);
    assign rd_page   = rd_data[WW-1:RW];
    assign rd_rank   = rd_data[RW-1:0];
    assign ent_v     = r_fvalid[r_di];
    assign pass_last = r_dv && (CW'(r_di) == act_m1);

    assign aged = (ent_v && (CW'(rd_rank) < r_old_age) && (rd_rank != RANK_TOP)) ?
                  rd_rank + RW'(1) : rd_rank;

    always_comb begin
        wr_en   = (r_state == ST_UPDATE) && r_dv && ((r_di == r_sel) || ent_v);
        wr_data = (r_di == r_sel) ? {r_page, RW'(0)} : {rd_page, aged};
    end

    lrupr_frame_mem #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (WW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_di),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_cnt[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (pass_last) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (pass_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_status.busy = (r_state != ST_IDLE);
        o_status.done = (r_state == ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
            r_dv     <= 1'b0;
            r_fvalid <= '0;
            r_faults <= '0;
        end else begin
            r_dv <= rd_en;
            if (((r_state == ST_IDLE) && i_start) || (r_state == ST_DECIDE)) begin
                r_rd_cnt <= '0;
            end else if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if ((r_state == ST_UPDATE) && r_dv && (r_di == r_sel)) begin
                r_fvalid[r_di] <= 1'b1;
            end else if ((r_state == ST_DONE) && i_res_take && r_last) begin
                r_fvalid <= '0;
            end
            if ((r_state == ST_DECIDE) && !r_found && (r_faults != '1)) begin
                r_faults <= r_faults + FAULT_W'(1);
            end else if ((r_state == ST_DONE) && i_res_take && r_last) begin
                r_faults <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_di <= r_rd_cnt[AW-1:0];
        if ((r_state == ST_IDLE) && i_start) begin
            r_page     <= i_page;
            r_last     <= i_last;
            r_found    <= 1'b0;
            r_empty    <= 1'b0;
            r_old_idx  <= '0;
            r_old_rank <= '0;
        end
        if ((r_state == ST_SCAN) && r_dv) begin
            if (!r_found && ent_v && (rd_page == r_page)) begin
                r_found    <= 1'b1;
                r_hit_idx  <= r_di;
                r_hit_rank <= rd_rank;
            end
            if (!r_empty && !ent_v) begin
                r_empty     <= 1'b1;
                r_empty_idx <= r_di;
            end
            // ties keep the lower frame
            if ((r_di == '0) || (ent_v && (rd_rank > r_old_rank))) begin
                r_old_idx  <= r_di;
                r_old_rank <= rd_rank;
                r_old_page <= rd_page;
            end
        end
        if (r_state == ST_DECIDE) begin
            if (r_found) begin
                r_sel     <= r_hit_idx;
                r_old_age <= CW'(r_hit_rank);
                r_ev      <= 1'b0;
            end else if (r_empty) begin
                r_sel     <= r_empty_idx;
                r_old_age <= MAX_N;
                r_ev      <= 1'b0;
            end else begin
                r_sel     <= r_old_idx;
                r_old_age <= CW'(r_old_rank);
                r_ev      <= 1'b1;
            end
        end
    end

    always_comb begin
        o_res.hit           = r_found;
        o_res.frame_index   = FRAME_IDX_W'(r_sel);
        o_res.evicted_valid = r_ev;
        o_res.fault_count   = r_faults;
        o_res_page          = r_ev ? r_old_page : '0;
    end

endmodule

>>> design/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// One page reference per transaction; returns hit/miss, the frame used, any
// evicted page and the saturating fault count. Frame pages and recency ranks
// live in a small frame memory read one entry per cycle. A lookup pass and an
// ageing pass each walk the n active frames through the single read port of
// the frame memory, n being the active frame count. The result sits in an
// output register, so the next reference is taken while it waits. A reference
// marked last clears frames and count after its result.
// ----------------------------------------------------------------------------
module lru_page_replacement import lrupr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PAGE_BITS-1:0]   i_page,
    input  logic                   i_last_reference,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_hit,
    output logic [FRAME_IDX_W-1:0] o_frame_index,
    output logic                   o_evicted_valid,
    output logic [PAGE_BITS-1:0]   o_evicted_page,
    output logic [FAULT_W-1:0]     o_fault_count
);

    logic [CFG_W-1:0]     r_frames_in_use;
    logic                 r_o_valid;
    t_res_ctl             r_res;
    logic [PAGE_BITS-1:0] r_ev_page;

    t_eng_status          eng_status;
    t_res_ctl             eng_res;
    logic [PAGE_BITS-1:0] eng_page;
    logic                 res_take;
    logic                 start;

    assign start    = i_valid && !eng_status.busy;
    assign res_take = eng_status.done && (!r_o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_FRAMES_RESET;
        end else if (i_cfg_wr_en) begin
            r_frames_in_use <= i_cfg_wr_data;
        end
    end

    lrupr_engine #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_page          (i_page),
        .i_last          (i_last_reference),
        .i_frames_in_use (r_frames_in_use),
        .i_res_take      (res_take),
        .o_status        (eng_status),
        .o_res           (eng_res),
        .o_res_page      (eng_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_take) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_res     <= eng_res;
            r_ev_page <= eng_page;
        end
    end

    assign o_stall         = eng_status.busy;
    assign o_valid         = r_o_valid;
    assign o_hit           = r_res.hit;
    assign o_frame_index   = r_res.frame_index;
    assign o_evicted_valid = r_res.evicted_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_res.fault_count;

`include "lru_page_replacement_macros.svh"

    `LRUPR_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "idle after accept")
    `LRUPR_ASSERT_SAME(a_hit_no_evict, o_valid, !(o_hit && o_evicted_valid), "hit with eviction")
    `LRUPR_ASSERT_SAME(a_evict_page_zero, o_valid && !o_evicted_valid, o_evicted_page == '0, "stray evicted page")

endmodule

>>> tb/lru_page_replacement_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_test
// Drives page references into the LRU page replacement block and checks every
// result transaction against an in-bench model of the frames, their recency
// ranks and the fault counter. A short directed table comes first, then
// reference strings with locality under four idling mixes and several frame
// counts. A long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module lru_page_replacement_test;
    import lrupr_pkg::*;

    localparam int FRAME_SLOTS   = MAX_FRAMES_DEF;
    localparam int PAGE_W        = PAGE_BITS_DEF;
    localparam int FAULT_SAT     = 65535;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SEG_REFS      = 240;
    localparam int TAIL_CYCLES   = 2 * FRAME_SLOTS + 24;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [FAULT_W-1:0]     fault_count;
    } t_lookup_result;

    typedef struct packed {
        logic               is_cfg;
        logic [CFG_W-1:0]   frames;
        logic [PAGE_W-1:0]  page;
        logic               last;
        logic               typed;
        t_lookup_result     want;
    } t_step_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wr_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [PAGE_W-1:0]      i_page = '0;
    logic                   i_last_reference = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_hit;
    logic [FRAME_IDX_W-1:0] o_frame_index;
    logic                   o_evicted_valid;
    logic [PAGE_W-1:0]      o_evicted_page;
    logic [FAULT_W-1:0]     o_fault_count;

    logic [PAGE_W-1:0] slot_page [FRAME_SLOTS];
    bit                slot_valid[FRAME_SLOTS];
    int                slot_rank [FRAME_SLOTS];
    int                model_faults;
    int                model_frames;

    t_lookup_result awaited_outcomes[$];
    t_step_row      directed_steps[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_granted  = 0;
    int hold_left      = 0;

    always #1 i_clk = ~i_clk;

    lru_page_replacement dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_page           (i_page),
        .i_last_reference (i_last_reference),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hit            (o_hit),
        .o_frame_index    (o_frame_index),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_count    (o_fault_count)
    );

    function automatic void clear_slots();
        int i;
        for (i = 0; i < FRAME_SLOTS; i++) begin
            slot_page[i]  = '0;
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end
        model_faults = 0;
    endfunction

    function automatic t_lookup_result predict_lookup(input logic [PAGE_W-1:0] pg,
                                                      input logic lst);
        t_lookup_result r;
        int  n, i, sel, age, oldest;
        bit  found, empty;
        r     = '0;
        found = 1'b0;
        empty = 1'b0;
        sel   = 0;
        n     = model_frames;
        if (n == 0) n = 1;
        if (n > FRAME_SLOTS) n = FRAME_SLOTS;
        for (i = 0; i < n; i++) begin
            if (!found && slot_valid[i] && slot_page[i] == pg) begin
                found = 1'b1;
                sel   = i;
            end
        end
        if (found) begin
            age = slot_rank[sel];
        end else begin
            for (i = 0; i < n; i++) begin
                if (!empty && !slot_valid[i]) begin
                    empty = 1'b1;
                    sel   = i;
                end
            end
            if (empty) begin
                slot_valid[sel] = 1'b1;
                age = FRAME_SLOTS;
            end else begin
                oldest = 0;
                sel    = 0;
                for (i = 0; i < n; i++) begin
                    if (slot_rank[i] > oldest) begin
                        oldest = slot_rank[i];
                        sel    = i;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = slot_page[sel];
                age = slot_rank[sel];
            end
            slot_page[sel] = pg;
            if (model_faults < FAULT_SAT) model_faults++;
        end
        // ageing: only frames younger than the touched one grow older
        for (i = 0; i < n; i++) begin
            if (i != sel && slot_valid[i] && slot_rank[i] < age &&
                slot_rank[i] < FRAME_SLOTS - 1) begin
                slot_rank[i]++;
            end
        end
        slot_rank[sel] = 0;
        r.hit         = found;
        r.frame_index = FRAME_IDX_W'(sel);
        r.fault_count = FAULT_W'(model_faults);
        if (lst) clear_slots();
        return r;
    endfunction

    function automatic t_step_row ref_row(input logic [PAGE_W-1:0] pg, input logic lst);
        t_step_row s;
        s       = '0;
        s.page  = pg;
        s.last  = lst;
        return s;
    endfunction

    function automatic t_step_row known_row(input logic [PAGE_W-1:0] pg, input logic hit,
                                            input int frame, input int faults);
        t_step_row s;
        s                  = '0;
        s.page             = pg;
        s.typed            = 1'b1;
        s.want.hit         = hit;
        s.want.frame_index = FRAME_IDX_W'(frame);
        s.want.fault_count = FAULT_W'(faults);
        return s;
    endfunction

    function automatic t_step_row cfg_row(input logic [CFG_W-1:0] v);
        t_step_row s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.frames = v;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_lookup_result w;
        if (awaited_outcomes.size() == 0) begin
            report_mismatch("result with nothing awaited", 32'(o_frame_index), 0);
            return;
        end
        w = awaited_outcomes.pop_front();
        if (o_hit !== w.hit) report_mismatch("hit", 32'(o_hit), 32'(w.hit));
        if (o_frame_index !== w.frame_index)
            report_mismatch("frame_index", 32'(o_frame_index), 32'(w.frame_index));
        if (o_evicted_valid !== w.evicted_valid)
            report_mismatch("evicted_valid", 32'(o_evicted_valid), 32'(w.evicted_valid));
        if (o_evicted_page !== w.evicted_page)
            report_mismatch("evicted_page", 32'(o_evicted_page), 32'(w.evicted_page));
        if (o_fault_count !== w.fault_count)
            report_mismatch("fault_count", 32'(o_fault_count), 32'(w.fault_count));
    endtask

    // result side: checking, random stall and the long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) check_result();
        if (hold_left == 0 && holds_granted != holds_asked) begin
            holds_granted = holds_asked;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) hold_left--;
        i_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic offer_ref(input logic [PAGE_W-1:0] pg, input logic lst,
                             input bit typed, input t_lookup_result want);
        t_lookup_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_page           <= pg;
        i_last_reference <= lst;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predicted = predict_lookup(pg, lst);
        awaited_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic drain_and_write(input logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        model_frames = v;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_step_row         row;
        t_lookup_result    none;
        logic [CFG_W-1:0]  seg_frames[8];
        logic [PAGE_W-1:0] pg, base;
        logic              lst;
        int                seg, items, k, len, ws, roll;
        bit                broken;

        none = '0;
        model_frames = CFG_FRAMES_RESET;
        clear_slots();

        // after reset: eight frames
        directed_steps.push_back(known_row(16'h0000, 1'b0, 0, 1));
        directed_steps.push_back(known_row(16'hFFFF, 1'b0, 1, 2));
        directed_steps.push_back(known_row(16'h0000, 1'b1, 0, 2));
        for (k = 2; k < 8; k++) directed_steps.push_back(ref_row(PAGE_W'(k), 1'b0));
        directed_steps.push_back(ref_row(16'h0008, 1'b0));
        directed_steps.push_back(ref_row(16'hFFFF, 1'b1));
        directed_steps.push_back(known_row(16'hFFFF, 1'b0, 0, 1));
        directed_steps.push_back(ref_row(16'h1234, 1'b0));
        directed_steps.push_back(ref_row(16'h5678, 1'b0));
        directed_steps.push_back(ref_row(16'h9ABC, 1'b0));
        // shrink mid-string, then grow back so stale ranks tie with live ones
        directed_steps.push_back(cfg_row(4'd2));
        directed_steps.push_back(ref_row(16'h9ABC, 1'b0));
        directed_steps.push_back(ref_row(16'h0001, 1'b0));
        directed_steps.push_back(cfg_row(4'd4));
        directed_steps.push_back(ref_row(16'h4321, 1'b0));
        directed_steps.push_back(ref_row(16'h0000, 1'b1));
        // zero count acts as one frame
        directed_steps.push_back(cfg_row(4'd0));
        directed_steps.push_back(known_row(16'hAAAA, 1'b0, 0, 1));
        directed_steps.push_back(ref_row(16'h5555, 1'b0));
        // oversized count acts as eight
        directed_steps.push_back(cfg_row(4'd15));
        directed_steps.push_back(ref_row(16'h5555, 1'b0));
        directed_steps.push_back(ref_row(16'hAAAA, 1'b1));

        seg_frames[0] = 4'd8;
        seg_frames[1] = 4'd1;
        seg_frames[2] = 4'd0;
        seg_frames[3] = 4'd15;
        seg_frames[4] = 4'd4;
        seg_frames[5] = CFG_W'($urandom_range(15));
        seg_frames[6] = 4'd2;
        seg_frames[7] = CFG_W'($urandom_range(15));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[idx]) begin
            row = directed_steps[idx];
            if (row.is_cfg) drain_and_write(row.frames);
            else offer_ref(row.page, row.last, row.typed, row.want);
        end

        for (seg = 0; seg < 8; seg++) begin
            drain_and_write(seg_frames[seg]);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (seg == 0) holds_asked++;
            items = 0;
            while (items < SEG_REFS) begin
                // one reference string with a small working set
                ws     = $urandom_range(1, 12);
                base   = PAGE_W'($urandom);
                len    = $urandom_range(3, 60);
                broken = ($urandom_range(9) == 0);
                for (k = 0; k < len && items < SEG_REFS; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 8) pg = PAGE_W'($urandom);
                    else if (roll == 8) pg = '0;
                    else if (roll == 9) pg = '1;
                    else pg = base + PAGE_W'($urandom_range(ws - 1));
                    lst = (k == len - 1) && !broken;
                    if ($urandom_range(99) < 2) lst = 1'b1;
                    offer_ref(pg, lst, 1'b0, none);
                    items++;
                end
            end
        end

        i_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_outcomes.size() != 0)
            report_mismatch("results still awaited", awaited_outcomes.size(), 0);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
